// ===== src/tsc_charge_current_deposit_3d_macros.svh =====
// Assertion macros shared by the deposit block.
// Expects clk and rst in scope at the point of use.
`ifndef TSC_CHARGE_CURRENT_DEPOSIT_3D_MACROS_SVH
`define TSC_CHARGE_CURRENT_DEPOSIT_3D_MACROS_SVH

// Same-cycle implication.
`define TSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tsc_dep_pkg.sv =====
// Types and fixed constants of the TSC charge/current deposit block.
// No dependencies.
package tsc_dep_pkg;

  localparam logic [1:0] CMD_DEPOSIT = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [1:0] COMP_RHO = 2'd0;
  localparam logic [1:0] COMP_JX  = 2'd1;
  localparam logic [1:0] COMP_JY  = 2'd2;
  localparam logic [1:0] COMP_JZ  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [2:0] REG_INV_X   = 3'd0;
  localparam logic [2:0] REG_INV_Y   = 3'd1;
  localparam logic [2:0] REG_INV_Z   = 3'd2;
  localparam logic [2:0] REG_INV_VOL = 3'd3;
  localparam logic [2:0] REG_DS_X    = 3'd4;
  localparam logic [2:0] REG_DS_Y    = 3'd5;
  localparam logic [2:0] REG_DS_Z    = 3'd6;

  localparam logic [23:0] INV_RESET = 24'd65536;
  localparam logic [39:0] AMP_CAP   = 40'hFF_FFFF_FFFF;
  localparam logic signed [49:0] ACC_MAX = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] ACC_MIN = -50'sh0_8000_0000_0000;
  localparam logic signed [59:0] HALF32  = 60'sd2147483648;
  localparam logic signed [34:0] QUART32 = 35'sd1073741824;
  localparam logic [31:0] THREE_QUART32  = 32'd3221225472;
  localparam logic [49:0] ONE32          = 50'd4294967296;
  localparam logic [5:0]  DIV_STEPS_M1   = 6'd56;
  localparam logic [41:0] SQRT_TOP_BIT   = 42'd1099511627776;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CLR, S_RD0, S_RD1,
    S_AMP0, S_AMP1, S_AMP2,
    S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_DIV, S_SQRT,
    S_MG0, S_MG1, S_MG2,
    S_AX0, S_AX1, S_AX2, S_AX3, S_AX4,
    S_BND, S_ADR0, S_ADR1, S_ADR2,
    S_N0, S_N1, S_N2, S_N3, S_DONE
  } state_t;

endpackage

// ===== src/tsc_charge_current_deposit_3d.sv =====
// Second-order (TSC) charge/current deposit onto an on-chip 3D grid; uses tsc_dep_pkg and macros.
// Current deposits add a 57-step divider and a 21-step square root to the charge path;
// one item at a time: one shared 40x32 multiplier and a single-port grid RAM, and each
// stencil node passes through the states S_N0 to S_N3 in turn.
// Reset: synchronous; a sweep zeroes the grid before the first transfer is taken
// (config writes still land). The result register frees the input while a result waits.
module tsc_charge_current_deposit_3d
  import tsc_dep_pkg::*;
#(
  parameter int GRID_NX = 16,
  parameter int GRID_NY = 16,
  parameter int GRID_NZ = 16
) (
  input  logic         clk,
  input  logic         rst,
  // config write port
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [23:0]  cfg_data,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x[31:0] pos_y[63:32] pos_z[95:64] mom_x[120:96] mom_y[145:121]
  // mom_z[170:146] charge[178:171] weight[210:179] component[212:211]
  // cell_index[225:213], zero fill to 231
  input  logic [231:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // cell_value[47:0] status[49:48], zero fill to 55
  output logic [55:0]  m_tdata
);

`include "tsc_charge_current_deposit_3d_macros.svh"

  localparam int DEPTH  = (GRID_NX + 1) * (GRID_NY + 1) * (GRID_NZ + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
  // row strides of the three possible grid shapes
  localparam logic [ADDR_W-1:0] SX_BASE = ADDR_W'(GRID_NY * GRID_NZ);
  localparam logic [ADDR_W-1:0] SX_JY   = ADDR_W'((GRID_NY + 1) * GRID_NZ);
  localparam logic [ADDR_W-1:0] SX_JZ   = ADDR_W'(GRID_NY * (GRID_NZ + 1));
  localparam logic [ADDR_W-1:0] SY_BASE = ADDR_W'(GRID_NZ);
  localparam logic [ADDR_W-1:0] SY_JZ   = ADDR_W'(GRID_NZ + 1);

  state_t state, state_next;

  // configuration
  logic [23:0] inv_x, inv_y, inv_z, inv_vol;
  logic signed [15:0] ds_x, ds_y, ds_z;

  // captured item
  logic [1:0] cmd, comp;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [24:0] mom_x, mom_y, mom_z;
  logic signed [7:0]  charge;
  logic [31:0] weight;
  logic [12:0] cell_idx;

  // shared multiplier
  logic [39:0] mul_a;
  logic [31:0] mul_b;
  logic [71:0] mul_p;

  // amplitude and gamma
  logic [39:0] amp;
  logic        neg, sat;
  logic [49:0] acc;
  logic [34:0] rem;
  logic [40:0] quot;
  logic [5:0]  div_cnt;
  logic [41:0] sq_q, sq_r, sq_bit;

  // per axis
  logic [1:0]  ax;
  logic signed [57:0] v;
  logic signed [32:0] d;
  logic [31:0] ad;
  logic signed [27:0] loc_x, loc_y, loc_z;
  logic [15:0] wx [3];
  logic [15:0] wy [3];
  logic [15:0] wz [3];

  // stencil walk
  logic [1:0] ni, nj, nk;
  logic [ADDR_W-1:0] base, node_addr, clr_ptr;

  // grid RAM
  logic [47:0] grid_mem [DEPTH];
  logic [47:0] rd_data, mem_wd;
  logic [ADDR_W-1:0] mem_addr;
  logic mem_we, mem_re;

  // result
  logic [47:0] res_value;
  logic [1:0]  res_status;

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic signed [31:0] sel_pos;
  logic [23:0] sel_inv;
  logic signed [15:0] sel_ds;
  logic dual;
  logic [31:0] pos_mag;
  logic [7:0]  q_mag;
  logic [24:0] px_mag, py_mag, pz_mag, pc_mag;
  logic pc_neg;

  always_comb begin
    case (ax)
      2'd0:    begin sel_pos = pos_x; sel_inv = inv_x; sel_ds = ds_x; end
      2'd1:    begin sel_pos = pos_y; sel_inv = inv_y; sel_ds = ds_y; end
      default: begin sel_pos = pos_z; sel_inv = inv_z; sel_ds = ds_z; end
    endcase
    dual    = (comp == 2'(ax + 2'd1));
    pos_mag = sel_pos[31] ? 32'(-sel_pos) : 32'(sel_pos);
    q_mag   = charge[7] ? 8'(-charge) : 8'(charge);
    px_mag  = mom_x[24] ? 25'(-mom_x) : 25'(mom_x);
    py_mag  = mom_y[24] ? 25'(-mom_y) : 25'(mom_y);
    pz_mag  = mom_z[24] ? 25'(-mom_z) : 25'(mom_z);
    case (comp)
      COMP_JX: begin pc_mag = px_mag; pc_neg = mom_x[24]; end
      COMP_JY: begin pc_mag = py_mag; pc_neg = mom_y[24]; end
      default: begin pc_mag = pz_mag; pc_neg = mom_z[24]; end
    endcase
  end

  // axis rounding: node is v rounded half away from zero
  logic signed [59:0] v_ext, v_abs, d_full;
  logic [25:0] rnd;
  logic signed [26:0] n_node;
  logic signed [32:0] d_new;
  logic signed [27:0] loc_new;

  always_comb begin
    v_ext   = 60'(v);
    v_abs   = v_ext[59] ? -v_ext : v_ext;
    rnd     = 26'((v_abs + HALF32) >>> 32);
    n_node  = v_ext[59] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
    d_full  = v_ext - $signed({n_node, 32'd0});
    d_new   = d_full[32:0];
    loc_new = 28'(n_node) - 28'(sel_ds) - 28'sd1;
  end

  // axis weights from d and d^2
  logic [31:0] d2;
  logic signed [34:0] lo_w, hi_w;
  logic [31:0] mid_w;

  always_comb begin
    d2    = mul_p[63:32];
    lo_w  = $signed({3'b0, d2}) - 35'(d) + QUART32;
    hi_w  = $signed({3'b0, d2}) + 35'(d) + QUART32;
    mid_w = THREE_QUART32 - d2;
    if (lo_w < 0) lo_w = '0;
    if (hi_w < 0) hi_w = '0;
  end

  // stencil bounds against the component's grid extents
  logic [8:0] ext_x, ext_y, ext_z;
  logic oob;

  always_comb begin
    ext_x = 9'(GRID_NX) + {8'd0, comp == COMP_JX};
    ext_y = 9'(GRID_NY) + {8'd0, comp == COMP_JY};
    ext_z = 9'(GRID_NZ) + {8'd0, comp == COMP_JZ};
    oob = loc_x[27] || loc_y[27] || loc_z[27]
       || (loc_x + 28'sd2 >= $signed(28'(ext_x)))
       || (loc_y + 28'sd2 >= $signed(28'(ext_y)))
       || (loc_z + 28'sd2 >= $signed(28'(ext_z)));
  end

  // stencil addressing
  logic [ADDR_W-1:0] stride_x, stride_y, off_i, off_j;

  always_comb begin
    case (comp)
      COMP_JY: stride_x = SX_JY;
      COMP_JZ: stride_x = SX_JZ;
      default: stride_x = SX_BASE;
    endcase
    stride_y  = (comp == COMP_JZ) ? SY_JZ : SY_BASE;
    case (ni)
      2'd0:    off_i = '0;
      2'd1:    off_i = stride_x;
      default: off_i = stride_x << 1;
    endcase
    case (nj)
      2'd0:    off_j = '0;
      2'd1:    off_j = stride_y;
      default: off_j = stride_y << 1;
    endcase
    node_addr = base + off_i + off_j + ADDR_W'(nk);
  end

  // accumulate one node, saturating at the 48-bit range
  logic [47:0] contrib;
  logic signed [49:0] node_sum;
  logic node_sat;

  always_comb begin
    contrib  = mul_p[63:16];
    node_sum = 50'($signed(rd_data));
    node_sum = neg ? node_sum - $signed({2'b0, contrib})
                   : node_sum + $signed({2'b0, contrib});
    node_sat = 1'b0;
    if (node_sum > ACC_MAX) begin
      node_sum = ACC_MAX;
      node_sat = 1'b1;
    end else if (node_sum < ACC_MIN) begin
      node_sum = ACC_MIN;
      node_sat = 1'b1;
    end
  end

  // divider and square root steps
  logic [35:0] rem_sh;
  logic [35:0] div_diff;
  logic        div_take;
  logic [40:0] quot_new;
  logic [41:0] sq_t;

  always_comb begin
    rem_sh   = {rem, div_cnt == DIV_STEPS_M1};
    div_diff = rem_sh - {2'b0, acc[49:16]};
    div_take = (rem_sh >= {2'b0, acc[49:16]});
    quot_new = {quot[39:0], div_take};
    sq_t     = sq_r + sq_bit;
  end

  logic last_node;
  assign last_node = (ni == 2'd2) && (nj == 2'd2) && (nk == 2'd2);

  logic take_in, out_load;
  assign take_in  = s_tvalid && s_tready;
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: if (clr_ptr == CLR_LAST) state_next = S_IDLE;
      S_IDLE: begin
        if (take_in) begin
          case (s_tuser)
            CMD_DEPOSIT: state_next = S_AMP0;
            CMD_READ:    state_next = S_RD0;
            CMD_CLEAR:   state_next = S_CLR;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_CLR:  if (clr_ptr == CLR_LAST) state_next = S_DONE;
      S_RD0:  state_next = (32'(cell_idx) < 32'(DEPTH)) ? S_RD1 : S_DONE;
      S_RD1:  state_next = S_DONE;
      S_AMP0: state_next = S_AMP1;
      S_AMP1: state_next = S_AMP2;
      S_AMP2: state_next = (comp == COMP_RHO) ? S_AX0 : S_SQ0;
      S_SQ0:  state_next = S_SQ1;
      S_SQ1:  state_next = S_SQ2;
      S_SQ2:  state_next = S_SQ3;
      S_SQ3:  state_next = S_DIV;
      S_DIV:  if (div_cnt == '0) state_next = S_SQRT;
      S_SQRT: if (sq_bit[0]) state_next = S_MG0;
      S_MG0:  state_next = S_MG1;
      S_MG1:  state_next = S_MG2;
      S_MG2:  state_next = S_AX0;
      S_AX0:  state_next = S_AX1;
      S_AX1:  state_next = S_AX2;
      S_AX2:  state_next = S_AX3;
      S_AX3:  state_next = S_AX4;
      S_AX4:  state_next = (ax == 2'd2) ? S_BND : S_AX0;
      S_BND:  state_next = oob ? S_DONE : S_ADR0;
      S_ADR0: state_next = S_ADR1;
      S_ADR1: state_next = S_ADR2;
      S_ADR2: state_next = S_N0;
      S_N0:   state_next = S_N1;
      S_N1:   state_next = S_N2;
      S_N2:   state_next = S_N3;
      S_N3:   state_next = last_node ? S_DONE : S_N0;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: multiplier operands and RAM control
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = node_addr;
    mem_wd   = node_sum[47:0];
    s_tready = 1'b0;
    case (state)
      S_IDLE: s_tready = 1'b1;
      S_INIT, S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_ptr;
        mem_wd   = '0;
      end
      S_RD0: begin
        mem_re   = 1'b1;
        mem_addr = ADDR_W'(cell_idx);
      end
      S_AMP0: begin mul_a = 40'(weight);       mul_b = 32'(inv_vol); end
      S_AMP1: begin mul_a = mul_p[55:16];      mul_b = 32'(q_mag);   end
      S_SQ0:  begin mul_a = 40'(px_mag);       mul_b = 32'(px_mag);  end
      S_SQ1:  begin mul_a = 40'(py_mag);       mul_b = 32'(py_mag);  end
      S_SQ2:  begin mul_a = 40'(pz_mag);       mul_b = 32'(pz_mag);  end
      S_MG0:  begin mul_a = amp;               mul_b = sq_r[31:0];   end
      S_MG1:  begin mul_a = mul_p[59:20];      mul_b = 32'(pc_mag);  end
      S_AX0:  begin mul_a = 40'(pos_mag);      mul_b = 32'(sel_inv); end
      S_AX3:  begin mul_a = 40'(ad);           mul_b = ad;           end
      S_ADR0: begin mul_a = 40'($unsigned(loc_x)); mul_b = 32'(stride_x); end
      S_ADR1: begin mul_a = 40'($unsigned(loc_y)); mul_b = 32'(stride_y); end
      S_N0: begin
        mul_a  = 40'(wx[ni]);
        mul_b  = 32'(wy[nj]);
        mem_re = 1'b1;
      end
      S_N1: begin mul_a = 40'(mul_p[31:0]);    mul_b = 32'(wz[nk]);  end
      S_N2: begin mul_a = amp;                 mul_b = 32'(mul_p[47:24]); end
      S_N3: mem_we = 1'b1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier, registered product
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // ---------------------------------------------------------------------------
  // Grid RAM: one port, registered read
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_addr] <= mem_wd;
    if (mem_re) rd_data <= grid_mem[mem_addr];
  end

  // ---------------------------------------------------------------------------
  // Control registers and configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      clr_ptr  <= '0;
      m_tvalid <= 1'b0;
      inv_x    <= INV_RESET;
      inv_y    <= INV_RESET;
      inv_z    <= INV_RESET;
      inv_vol  <= INV_RESET;
      ds_x     <= '0;
      ds_y     <= '0;
      ds_z     <= '0;
    end else begin
      state <= state_next;
      // advance the clear sweep, wrap to zero at the end
      if (state == S_INIT || state == S_CLR) begin
        clr_ptr <= (clr_ptr == CLR_LAST) ? '0 : clr_ptr + 1'b1;
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (cfg_we) begin
        case (cfg_addr)
          REG_INV_X:   inv_x   <= cfg_data;
          REG_INV_Y:   inv_y   <= cfg_data;
          REG_INV_Z:   inv_z   <= cfg_data;
          REG_INV_VOL: inv_vol <= cfg_data;
          REG_DS_X:    ds_x    <= cfg_data[15:0];
          REG_DS_Y:    ds_y    <= cfg_data[15:0];
          REG_DS_Z:    ds_z    <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // result register: hold until the downstream transfer
  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= {6'd0, res_status, res_value};
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (take_in) begin
          cmd        <= s_tuser;
          pos_x      <= s_tdata[31:0];
          pos_y      <= s_tdata[63:32];
          pos_z      <= s_tdata[95:64];
          mom_x      <= s_tdata[120:96];
          mom_y      <= s_tdata[145:121];
          mom_z      <= s_tdata[170:146];
          charge     <= s_tdata[178:171];
          weight     <= s_tdata[210:179];
          comp       <= s_tdata[212:211];
          cell_idx   <= s_tdata[225:213];
          neg        <= s_tdata[178];
          sat        <= 1'b0;
          ax         <= '0;
          ni         <= '0;
          nj         <= '0;
          nk         <= '0;
          res_value  <= '0;
          res_status <= ST_OK;
        end
      end
      S_RD1: res_value <= rd_data;
      S_AMP2: begin
        // clamp amplitude after the charge product
        if (mul_p[47:0] > 48'(AMP_CAP)) begin
          amp <= AMP_CAP;
          sat <= 1'b1;
        end else begin
          amp <= mul_p[39:0];
        end
      end
      S_SQ0: acc <= ONE32;
      S_SQ1, S_SQ2: acc <= acc + mul_p[49:0];
      S_SQ3: begin
        acc     <= acc + mul_p[49:0];
        rem     <= '0;
        quot    <= '0;
        div_cnt <= DIV_STEPS_M1;
      end
      S_DIV: begin
        // one quotient bit per cycle of 2^56 / s16
        rem     <= div_take ? div_diff[34:0] : rem_sh[34:0];
        quot    <= quot_new;
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == '0) begin
          sq_q   <= {1'b0, quot_new};
          sq_r   <= '0;
          sq_bit <= SQRT_TOP_BIT;
        end
      end
      S_SQRT: begin
        // one root bit per cycle
        if (sq_q >= sq_t) begin
          sq_q <= sq_q - sq_t;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      S_MG2: begin
        // clamp amplitude after the momentum product
        if (mul_p[71:16] > 56'(AMP_CAP)) begin
          amp <= AMP_CAP;
          sat <= 1'b1;
        end else begin
          amp <= mul_p[55:16];
        end
        neg <= neg ^ pc_neg;
      end
      S_AX1: begin
        if (sel_pos[31]) v <= -$signed({2'b0, mul_p[55:0]}) + (dual ? 58'sd2147483648 : 58'sd0);
        else             v <=  $signed({2'b0, mul_p[55:0]}) + (dual ? 58'sd2147483648 : 58'sd0);
      end
      S_AX2: begin
        d  <= d_new;
        ad <= d_new[32] ? 32'(-d_new) : 32'(d_new);
        case (ax)
          2'd0:    loc_x <= loc_new;
          2'd1:    loc_y <= loc_new;
          default: loc_z <= loc_new;
        endcase
      end
      S_AX4: begin
        case (ax)
          2'd0: begin
            wx[0] <= lo_w[32:17]; wx[1] <= mid_w[31:16]; wx[2] <= hi_w[32:17];
          end
          2'd1: begin
            wy[0] <= lo_w[32:17]; wy[1] <= mid_w[31:16]; wy[2] <= hi_w[32:17];
          end
          default: begin
            wz[0] <= lo_w[32:17]; wz[1] <= mid_w[31:16]; wz[2] <= hi_w[32:17];
          end
        endcase
        ax <= ax + 2'd1;
      end
      S_BND: if (oob) res_status <= ST_DROP;
      S_ADR1: base <= mul_p[ADDR_W-1:0];
      S_ADR2: base <= base + mul_p[ADDR_W-1:0] + loc_z[ADDR_W-1:0];
      S_N3: begin
        if (node_sat) sat <= 1'b1;
        if (last_node) begin
          res_status <= (sat || node_sat) ? ST_SAT : ST_OK;
        end
        // walk z fastest, then y, then x
        if (nk != 2'd2) begin
          nk <= nk + 2'd1;
        end else begin
          nk <= '0;
          if (nj != 2'd2) begin
            nj <= nj + 2'd1;
          end else begin
            nj <= '0;
            ni <= ni + 2'd1;
          end
        end
      end
      S_DONE: if (cmd == CMD_DEPOSIT && res_status == ST_OK && sat) res_status <= ST_SAT;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TSC_ASSERT_NXT(a_init_sweep_done, (state == S_INIT) && (clr_ptr == CLR_LAST), state == S_IDLE, "grid sweep after reset did not finish")
  `TSC_ASSERT_IMP(a_amp_capped, state == S_N0, amp <= AMP_CAP, "amplitude above cap in node loop")
  `TSC_ASSERT_IMP(a_node_in_grid, state == S_N0, 32'(node_addr) < 32'(DEPTH), "stencil address beyond grid")
  `TSC_ASSERT_IMP(a_status_code, m_tvalid, m_tdata[49:48] != 2'd3, "invalid status code")
  `TSC_ASSERT_NXT(a_take_busy, s_tvalid && s_tready, state != S_IDLE, "sequencer stayed idle after a transfer")

endmodule
